@@ design/phv_pkg.sv @@
// ----------------------------------------------------------------------------
// phv_pkg
// types, codes and tables shared by the container header validator
// ----------------------------------------------------------------------------
package phv_pkg;

   localparam int NTYPES = 9;
   localparam int TYPE_W = 4;
   localparam int SECT_W = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [31:0] HDR_BYTES = 32'd20;
   localparam logic [3:0] UNKNOWN_KIND = 4'd9;
   localparam logic [NTYPES-1:0] REQUIRED_MASK = 9'h01D;

   localparam logic [1:0] REG_BUFFER_LENGTH = 2'd0;
   localparam logic [1:0] REG_MAGIC_VALUE = 2'd1;
   localparam logic [1:0] REG_EXPECTED_VERSION = 2'd2;

   localparam logic KIND_DESC = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [3:0] STATUS_OK = 4'd0;
   localparam logic [3:0] STATUS_SHORT = 4'd1;
   localparam logic [3:0] STATUS_MAGIC = 4'd2;
   localparam logic [3:0] STATUS_VERSION = 4'd3;
   localparam logic [3:0] STATUS_TOTAL = 4'd4;
   localparam logic [3:0] STATUS_COUNT = 4'd5;
   localparam logic [3:0] STATUS_BOUNDS = 4'd6;
   localparam logic [3:0] STATUS_ENTRIES = 4'd7;
   localparam logic [3:0] STATUS_MISSING = 4'd8;
   localparam logic [3:0] STATUS_INDEX_LIMIT = 4'd9;

   typedef enum logic [3:0] {
      POS_MAGIC_LO = 4'd0,
      POS_MAGIC_HI = 4'd1,
      POS_VERSION  = 4'd2,
      POS_TOTAL    = 4'd3,
      POS_COUNT    = 4'd4,
      POS_TYPE     = 4'd5,
      POS_OFFSET   = 4'd6,
      POS_ENTRIES  = 4'd7,
      POS_SIZE     = 4'd8
   } phv_pos_type;

   typedef struct packed {
      logic [31:0] word;
      logic        first_word;
   } phv_req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  section_type;
      logic [31:0] section_offset;
      logic [15:0] entry_count;
      logic [31:0] section_bytes;
      logic [3:0]  status;
      logic        last;
   } phv_rsp_type;

   typedef struct packed {
      logic [31:0] buffer_length;
      logic [63:0] magic_value;
      logic [31:0] expected_version;
   } phv_cfg_type;

   typedef struct packed {
      logic              fire;
      logic [3:0]        status;
      logic [NTYPES-1:0] mask;
   } phv_event_type;

   typedef struct packed {
      logic        we;
      logic [3:0]  kind;
      logic [31:0] offset;
      logic [15:0] count;
      logic [31:0] size;
   } phv_store_type;

   function automatic logic [4:0] entry_bytes(input logic [3:0] k);
      logic [4:0] r;
      unique case (k)
         4'd1: r = 5'd8;
         4'd2: r = 5'd20;
         4'd3: r = 5'd22;
         4'd4: r = 5'd14;
         4'd5: r = 5'd12;
         4'd6: r = 5'd20;
         4'd8: r = 5'd24;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/phv_csr.sv @@
// ----------------------------------------------------------------------------
// phv_csr
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module phv_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [phv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [phv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [phv_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output phv_pkg::phv_cfg_type             cfg
);

   phv_pkg::phv_cfg_type cfg_ff, cfg_in;
   logic [1:0] idx;
   logic wr;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:3];
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            phv_pkg::REG_BUFFER_LENGTH: cfg_in.buffer_length = csr_pwdata[31:0];
            phv_pkg::REG_MAGIC_VALUE: cfg_in.magic_value = csr_pwdata;
            phv_pkg::REG_EXPECTED_VERSION: cfg_in.expected_version = csr_pwdata[31:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         phv_pkg::REG_BUFFER_LENGTH: csr_prdata = {32'd0, cfg_ff.buffer_length};
         phv_pkg::REG_MAGIC_VALUE: csr_prdata = cfg_ff.magic_value;
         phv_pkg::REG_EXPECTED_VERSION: csr_prdata = {32'd0, cfg_ff.expected_version};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/phv_parse.sv @@
// ----------------------------------------------------------------------------
// phv_parse
// request register and header / section table checks, one word per cycle while not busy
// ----------------------------------------------------------------------------
module phv_parse #(
   parameter int MAX_SECTIONS = 32,
   parameter int INDEX_LIMIT = 65535
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  phv_pkg::phv_req_type   req_payload,
   output logic                   req_stall,
   input  phv_pkg::phv_cfg_type   cfg,
   input  logic                   busy,
   output phv_pkg::phv_event_type ev,
   output phv_pkg::phv_store_type store
);

   logic in_valid_ff, in_valid_in;
   phv_pkg::phv_req_type in_data_ff, in_data_in;
   phv_pkg::phv_pos_type pos_ff, pos_in, pos_cur;
   logic dead_ff, dead_in;
   logic [31:0] held_ff, held_in;
   logic [phv_pkg::SECT_W-1:0] sect_ff, sect_in, sect_base, sect_dec;
   logic [3:0] rkind_ff, rkind_in;
   logic [31:0] roff_ff, roff_in;
   logic [31:0] rent_ff, rent_in;
   logic [phv_pkg::NTYPES-1:0] present_ff, present_in, present_base, present_new;
   logic [phv_pkg::NTYPES-1:0] over_ff, over_in, over_new, kind_bit;

   logic advance, act;
   logic [31:0] w;
   logic [31:0] blen;
   logic short_fail, magic_fail, version_fail, total_fail, count_fail, fit_fail;
   logic bound_fail, known, entries_fail, done, missing_fail, limit_fail, over_cur;
   logic [4:0] ebytes;
   logic [36:0] need;
   logic [35:0] fit_bytes;
   logic [31:0] keep_cnt;

   assign advance = in_valid_ff && !busy;
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign in_data_in = (req_valid && !req_stall) ? req_payload : in_data_ff;

   assign w = in_data_ff.word;
   assign blen = cfg.buffer_length;
   assign act = advance && (in_data_ff.first_word || !dead_ff);
   assign pos_cur = in_data_ff.first_word ? phv_pkg::POS_MAGIC_LO : pos_ff;
   assign present_base = in_data_ff.first_word ? '0 : present_ff;
   assign sect_base = in_data_ff.first_word ? '0 : sect_ff;

   assign short_fail = blen < phv_pkg::HDR_BYTES;
   assign magic_fail = {w, held_ff} != cfg.magic_value;
   assign version_fail = w != cfg.expected_version;
   assign total_fail = w != blen;
   assign count_fail = (w == 32'd0) || (w > 32'(MAX_SECTIONS));
   assign fit_bytes = {w, 4'd0} + {4'd0, phv_pkg::HDR_BYTES};
   assign fit_fail = fit_bytes > {4'd0, blen};

   assign bound_fail = (roff_ff > blen) || (w > (blen - roff_ff));
   assign known = rkind_ff < phv_pkg::UNKNOWN_KIND;
   assign ebytes = phv_pkg::entry_bytes(rkind_ff);
   assign need = {5'd0, rent_ff} * {32'd0, ebytes};
   assign entries_fail = known && ({5'd0, w} < need);
   assign keep_cnt = (ebytes == 5'd0) ? 32'd0 : rent_ff;
   assign over_cur = keep_cnt > 32'(INDEX_LIMIT);
   assign kind_bit = known ? (phv_pkg::NTYPES'(1) << rkind_ff) : '0;
   assign present_new = present_base | kind_bit;
   assign over_new = (over_ff & ~kind_bit) | (over_cur ? kind_bit : '0);
   assign sect_dec = sect_base - phv_pkg::SECT_W'(1);
   assign done = sect_dec == '0;
   assign missing_fail = (present_new & phv_pkg::REQUIRED_MASK) != phv_pkg::REQUIRED_MASK;
   assign limit_fail = |(present_new & over_new);

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (act) begin
         unique case (pos_cur)
            phv_pkg::POS_MAGIC_LO: pos_in = phv_pkg::POS_MAGIC_HI;
            phv_pkg::POS_MAGIC_HI: pos_in = phv_pkg::POS_VERSION;
            phv_pkg::POS_VERSION: pos_in = phv_pkg::POS_TOTAL;
            phv_pkg::POS_TOTAL: pos_in = phv_pkg::POS_COUNT;
            phv_pkg::POS_COUNT: pos_in = phv_pkg::POS_TYPE;
            phv_pkg::POS_TYPE: pos_in = phv_pkg::POS_OFFSET;
            phv_pkg::POS_OFFSET: pos_in = phv_pkg::POS_ENTRIES;
            phv_pkg::POS_ENTRIES: pos_in = phv_pkg::POS_SIZE;
            phv_pkg::POS_SIZE: pos_in = phv_pkg::POS_TYPE;
            default: pos_in = pos_cur;
         endcase
      end
   end

   // checks, record capture and events
   always_comb begin
      ev = '0;
      ev.status = phv_pkg::STATUS_OK;
      store = '0;
      store.kind = rkind_ff;
      store.offset = roff_ff;
      store.count = keep_cnt[15:0];
      store.size = w;
      dead_in = dead_ff;
      held_in = held_ff;
      sect_in = sect_ff;
      rkind_in = rkind_ff;
      roff_in = roff_ff;
      rent_in = rent_ff;
      present_in = present_ff;
      over_in = over_ff;
      if (act) begin
         dead_in = 1'b0;
         sect_in = sect_base;
         present_in = present_base;
         unique case (pos_cur)
            phv_pkg::POS_MAGIC_LO: begin
               held_in = w;
               if (short_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_SHORT;
               end
            end
            phv_pkg::POS_MAGIC_HI: begin
               if (magic_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_MAGIC;
               end
            end
            phv_pkg::POS_VERSION: begin
               if (version_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_VERSION;
               end
            end
            phv_pkg::POS_TOTAL: begin
               if (total_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_TOTAL;
               end
            end
            phv_pkg::POS_COUNT: begin
               sect_in = w[phv_pkg::SECT_W-1:0];
               if (count_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_COUNT;
               end else if (fit_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_BOUNDS;
               end
            end
            phv_pkg::POS_TYPE: begin
               rkind_in = (w > 32'd8) ? phv_pkg::UNKNOWN_KIND : w[3:0];
            end
            phv_pkg::POS_OFFSET: begin
               roff_in = w;
            end
            phv_pkg::POS_ENTRIES: begin
               rent_in = w;
            end
            phv_pkg::POS_SIZE: begin
               if (bound_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_BOUNDS;
               end else if (entries_fail) begin
                  ev.fire = 1'b1;
                  ev.status = phv_pkg::STATUS_ENTRIES;
               end else begin
                  store.we = known;
                  present_in = present_new;
                  over_in = over_new;
                  sect_in = sect_dec;
                  if (done) begin
                     ev.fire = 1'b1;
                     if (missing_fail) begin
                        ev.status = phv_pkg::STATUS_MISSING;
                     end else if (limit_fail) begin
                        ev.status = phv_pkg::STATUS_INDEX_LIMIT;
                     end else begin
                        ev.mask = present_new;
                     end
                  end
               end
            end
            default: begin
               dead_in = 1'b1;
            end
         endcase
         if (ev.fire) begin
            dead_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff <= phv_pkg::POS_MAGIC_LO;
         dead_ff <= 1'b1;
         sect_ff <= '0;
         present_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff <= pos_in;
         dead_ff <= dead_in;
         sect_ff <= sect_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      held_ff <= held_in;
      rkind_ff <= rkind_in;
      roff_ff <= roff_in;
      rent_ff <= rent_in;
      over_ff <= over_in;
   end

endmodule

@@ design/phv_emit.sv @@
// ----------------------------------------------------------------------------
// phv_emit
// kept section records, descriptor sequencing and the result register
// ----------------------------------------------------------------------------
module phv_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  phv_pkg::phv_event_type ev,
   input  phv_pkg::phv_store_type store,
   output logic                   busy,
   output logic                   rsp_valid,
   output phv_pkg::phv_rsp_type   rsp_payload,
   input  logic                   rsp_stall
);

   logic [31:0] kept_off_ff [phv_pkg::NTYPES];
   logic [15:0] kept_cnt_ff [phv_pkg::NTYPES];
   logic [31:0] kept_size_ff [phv_pkg::NTYPES];

   logic [phv_pkg::NTYPES-1:0] pend_ff, pend_in;
   logic stat_pend_ff, stat_pend_in;
   logic [3:0] stat_code_ff, stat_code_in;
   logic out_valid_ff, out_valid_in;
   phv_pkg::phv_rsp_type out_ff, out_in;
   logic out_free;
   logic [3:0] sel;

   assign busy = (|pend_ff) || stat_pend_ff;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // lowest pending type first
   always_comb begin
      sel = '0;
      for (int i = phv_pkg::NTYPES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = 4'(i);
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      stat_pend_in = stat_pend_ff;
      stat_code_in = stat_code_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
         if (|pend_ff) begin
            out_valid_in = 1'b1;
            out_in = '0;
            out_in.kind = phv_pkg::KIND_DESC;
            out_in.section_type = sel;
            out_in.section_offset = kept_off_ff[sel];
            out_in.entry_count = kept_cnt_ff[sel];
            out_in.section_bytes = kept_size_ff[sel];
            out_in.status = phv_pkg::STATUS_OK;
            pend_in = pend_ff & ~(phv_pkg::NTYPES'(1) << sel);
         end else if (stat_pend_ff) begin
            out_valid_in = 1'b1;
            out_in = '0;
            out_in.kind = phv_pkg::KIND_STATUS;
            out_in.status = stat_code_ff;
            out_in.last = 1'b1;
            stat_pend_in = 1'b0;
         end
      end
      if (ev.fire) begin
         pend_in = ev.mask;
         stat_pend_in = 1'b1;
         stat_code_in = ev.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         stat_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         stat_pend_ff <= stat_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_code_ff <= stat_code_in;
      out_ff <= out_in;
      if (store.we) begin
         kept_off_ff[store.kind] <= store.offset;
         kept_cnt_ff[store.kind] <= store.count;
         kept_size_ff[store.kind] <= store.size;
      end
   end

endmodule

@@ design/pack_header_validator_top.sv @@
// path: a request is registered, checked from that register, and its result passes the
//   pending registers into the output register
// throughput: one request per cycle while results are not pending, set by the single check
//   stage; a request that ends a container pauses the request side until its results, up to
//   nine descriptors and the status, reach the output register, and longer while results stall
// reset: synchronous, clears configuration and waits for a first-word request
// ----------------------------------------------------------------------------
// pack_header_validator_top
// container header and section table validator with apb-style configuration
// ----------------------------------------------------------------------------
module pack_header_validator_top #(
   parameter int MAX_SECTIONS = 32,
   parameter int INDEX_LIMIT = 65535
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  phv_pkg::phv_req_type             req_payload,
   output logic                             req_stall,
   output logic                             rsp_valid,
   output phv_pkg::phv_rsp_type             rsp_payload,
   input  logic                             rsp_stall,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [phv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [phv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [phv_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   phv_pkg::phv_cfg_type cfg;
   phv_pkg::phv_event_type ev;
   phv_pkg::phv_store_type store;
   logic busy;

   phv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   phv_parse #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .INDEX_LIMIT  (INDEX_LIMIT)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .cfg         (cfg),
      .busy        (busy),
      .ev          (ev),
      .store       (store)
   );

   phv_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .ev          (ev),
      .store       (store),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams container headers and section tables through the validator, writes
// the length, magic and version registers between phases, and checks every
// descriptor and status against a cycle-free model of the parse
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_SECTIONS = 32;
   localparam int INDEX_LIMIT = 65535;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   phv_pkg::phv_req_type req_payload = '0;
   logic req_stall;
   logic rsp_valid;
   phv_pkg::phv_rsp_type rsp_payload;
   logic rsp_stall = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [phv_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [phv_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [phv_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // register copies used by the checker
   logic [31:0] cfg_len = '0;
   logic [63:0] cfg_magic = '0;
   logic [31:0] cfg_version = '0;

   // parse state of the checker
   phv_pkg::phv_pos_type parse_pos = phv_pkg::POS_MAGIC_LO;
   logic [5:0] tables_left = '0;
   logic [31:0] magic_low = '0;
   logic [3:0] rec_type = '0;
   logic [31:0] rec_offset = '0;
   logic [31:0] rec_count = '0;
   logic [phv_pkg::NTYPES-1:0] seen_types = '0;
   logic [31:0] kept_offset [phv_pkg::NTYPES];
   logic [31:0] kept_count [phv_pkg::NTYPES];
   logic [31:0] kept_size [phv_pkg::NTYPES];
   bit parse_closed = 1'b1;

   phv_pkg::phv_req_type words_pending [$];
   phv_pkg::phv_rsp_type results_due [$];
   phv_pkg::phv_rsp_type rsp_want;
   logic req_taken = 1'b0;
   int req_gap = 0;
   int rsp_hold = 0;
   bit calm_run = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   pack_header_validator_top #(
      .MAX_SECTIONS(MAX_SECTIONS),
      .INDEX_LIMIT(INDEX_LIMIT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_payload(req_payload),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall(rsp_stall),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] record_size(input logic [3:0] t);
      logic [31:0] b;
      case (t)
         4'd1: b = 32'd8;
         4'd2: b = 32'd20;
         4'd3: b = 32'd22;
         4'd4: b = 32'd14;
         4'd5: b = 32'd12;
         4'd6: b = 32'd20;
         4'd8: b = 32'd24;
         default: b = 32'd0;
      endcase
      return b;
   endfunction

   task automatic end_parse(input logic [3:0] st);
      phv_pkg::phv_rsp_type item;
      item = '0;
      item.kind = phv_pkg::KIND_STATUS;
      item.status = st;
      item.last = 1'b1;
      results_due.push_back(item);
      parse_closed = 1'b1;
   endtask

   task automatic close_table();
      phv_pkg::phv_rsp_type item;
      int t;
      if ((seen_types & phv_pkg::REQUIRED_MASK) != phv_pkg::REQUIRED_MASK) begin
         end_parse(phv_pkg::STATUS_MISSING);
         return;
      end
      for (t = 0; t < phv_pkg::NTYPES; t++) begin
         if (seen_types[t] && kept_count[t] > INDEX_LIMIT) begin
            end_parse(phv_pkg::STATUS_INDEX_LIMIT);
            return;
         end
      end
      for (t = 0; t < phv_pkg::NTYPES; t++) begin
         if (seen_types[t]) begin
            item = '0;
            item.kind = phv_pkg::KIND_DESC;
            item.section_type = t[3:0];
            item.section_offset = kept_offset[t];
            item.entry_count = kept_count[t][15:0];
            item.section_bytes = kept_size[t];
            item.status = phv_pkg::STATUS_OK;
            results_due.push_back(item);
         end
      end
      end_parse(phv_pkg::STATUS_OK);
   endtask

   task automatic validate_word(input phv_pkg::phv_req_type r);
      logic [63:0] need;
      if (r.first_word) begin
         parse_closed = 1'b0;
         parse_pos = phv_pkg::POS_MAGIC_LO;
         tables_left = '0;
         seen_types = '0;
      end else if (parse_closed) begin
         return;
      end
      case (parse_pos)
         phv_pkg::POS_MAGIC_LO: begin
            if (cfg_len < phv_pkg::HDR_BYTES) begin
               end_parse(phv_pkg::STATUS_SHORT);
            end else begin
               magic_low = r.word;
               parse_pos = phv_pkg::POS_MAGIC_HI;
            end
         end
         phv_pkg::POS_MAGIC_HI: begin
            if ({r.word, magic_low} != cfg_magic) end_parse(phv_pkg::STATUS_MAGIC);
            else parse_pos = phv_pkg::POS_VERSION;
         end
         phv_pkg::POS_VERSION: begin
            if (r.word != cfg_version) end_parse(phv_pkg::STATUS_VERSION);
            else parse_pos = phv_pkg::POS_TOTAL;
         end
         phv_pkg::POS_TOTAL: begin
            if (r.word != cfg_len) end_parse(phv_pkg::STATUS_TOTAL);
            else parse_pos = phv_pkg::POS_COUNT;
         end
         phv_pkg::POS_COUNT: begin
            if (r.word == 0 || r.word > MAX_SECTIONS) begin
               end_parse(phv_pkg::STATUS_COUNT);
            end else if (({32'd0, r.word} << 4) + 64'd20 > {32'd0, cfg_len}) begin
               end_parse(phv_pkg::STATUS_BOUNDS);
            end else begin
               tables_left = r.word[5:0];
               parse_pos = phv_pkg::POS_TYPE;
            end
         end
         phv_pkg::POS_TYPE: begin
            rec_type = (r.word > 8) ? phv_pkg::UNKNOWN_KIND : r.word[3:0];
            parse_pos = phv_pkg::POS_OFFSET;
         end
         phv_pkg::POS_OFFSET: begin
            rec_offset = r.word;
            parse_pos = phv_pkg::POS_ENTRIES;
         end
         phv_pkg::POS_ENTRIES: begin
            rec_count = r.word;
            parse_pos = phv_pkg::POS_SIZE;
         end
         phv_pkg::POS_SIZE: begin
            if (rec_offset > cfg_len || r.word > cfg_len - rec_offset) begin
               end_parse(phv_pkg::STATUS_BOUNDS);
               return;
            end
            if (rec_type < phv_pkg::NTYPES) begin
               need = {32'd0, rec_count} * {32'd0, record_size(rec_type)};
               if ({32'd0, r.word} < need) begin
                  end_parse(phv_pkg::STATUS_ENTRIES);
                  return;
               end
               seen_types[rec_type] = 1'b1;
               kept_offset[rec_type] = rec_offset;
               kept_count[rec_type] = (record_size(rec_type) == 0) ? 32'd0 : rec_count;
               kept_size[rec_type] = r.word;
            end
            tables_left = tables_left - 1'b1;
            if (tables_left == 0) close_table();
            else parse_pos = phv_pkg::POS_TYPE;
         end
         default: parse_closed = 1'b1;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (words_pending.size() != 0) begin
            req_payload <= words_pending.pop_front();
            req_valid <= 1'b1;
            if (!calm_run && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else if (!calm_run && $urandom_range(0, 5) == 0) begin
         rsp_hold <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) validate_word(req_payload);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("result with none expected: kind %0h status %0h",
                   rsp_payload.kind, rsp_payload.status);
            error_count++;
         end else begin
            rsp_want = results_due.pop_front();
            compare_field("kind", 32'(rsp_want.kind), 32'(rsp_payload.kind));
            compare_field("section_type", 32'(rsp_want.section_type),
                          32'(rsp_payload.section_type));
            compare_field("section_offset", rsp_want.section_offset,
                          rsp_payload.section_offset);
            compare_field("entry_count", 32'(rsp_want.entry_count),
                          32'(rsp_payload.entry_count));
            compare_field("section_bytes", rsp_want.section_bytes, rsp_payload.section_bytes);
            compare_field("status", 32'(rsp_want.status), 32'(rsp_payload.status));
            compare_field("last", 32'(rsp_want.last), 32'(rsp_payload.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pack_header_validator_top test failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         phv_pkg::REG_BUFFER_LENGTH: cfg_len = value[31:0];
         phv_pkg::REG_MAGIC_VALUE: cfg_magic = value;
         phv_pkg::REG_EXPECTED_VERSION: cfg_version = value[31:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] len, input logic [63:0] magic,
                             input logic [31:0] version);
      csr_write(phv_pkg::REG_BUFFER_LENGTH, {32'd0, len});
      csr_write(phv_pkg::REG_MAGIC_VALUE, magic);
      csr_write(phv_pkg::REG_EXPECTED_VERSION, {32'd0, version});
   endtask

   task automatic settle();
      do @(posedge clock);
      while (words_pending.size() != 0 || req_valid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send(input logic [31:0] w, input logic first);
      phv_pkg::phv_req_type r;
      r.word = w;
      r.first_word = first;
      words_pending.push_back(r);
   endtask

   task automatic send_header_part(input int upto, input logic [31:0] n);
      logic [31:0] hdr [5];
      int i;
      hdr[0] = cfg_magic[31:0];
      hdr[1] = cfg_magic[63:32];
      hdr[2] = cfg_version;
      hdr[3] = cfg_len;
      hdr[4] = n;
      for (i = 0; i < upto; i++) send(hdr[i], i == 0);
   endtask

   task automatic send_header(input logic [31:0] n);
      send_header_part(5, n);
   endtask

   task automatic send_record(input logic [31:0] t, input logic [31:0] off,
                              input logic [31:0] cnt, input logic [31:0] size);
      send(t, 1'b0);
      send(off, 1'b0);
      send(cnt, 1'b0);
      send(size, 1'b0);
   endtask

   task automatic send_required();
      send_record(0, 100, 5, 64);
      send_record(2, 200, 3, 60);
      send_record(3, 300, 2, 44);
      send_record(4, 400, 1, 14);
   endtask

   // mostly well-formed container with random content, sometimes damaged
   task automatic send_random_container(output int n_words);
      logic [31:0] typ [32];
      logic [31:0] words [$];
      logic [31:0] off, cnt, size, room, slack, tmp, t_size;
      logic [63:0] need;
      int n_rec, j, k;
      n_rec = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(4, 10);
      for (j = 0; j < n_rec; j++)
         typ[j] = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8);
      if (n_rec >= 4 && $urandom_range(0, 7) != 0) begin
         typ[0] = 0;
         typ[1] = 2;
         typ[2] = 3;
         typ[3] = 4;
      end
      for (j = n_rec - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         tmp = typ[j];
         typ[j] = typ[k];
         typ[k] = tmp;
      end
      words.push_back(cfg_magic[31:0]);
      words.push_back(cfg_magic[63:32]);
      words.push_back(cfg_version);
      words.push_back(cfg_len);
      words.push_back(n_rec);
      for (j = 0; j < n_rec; j++) begin
         off = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, cfg_len / 2);
         room = (off > cfg_len) ? 32'd0 : cfg_len - off;
         case ($urandom_range(0, 9))
            0: cnt = 0;
            1: cnt = $urandom;
            2: cnt = $urandom_range(65530, 65540);
            default: cnt = $urandom_range(1, 3000);
         endcase
         t_size = (typ[j] > 8) ? 32'd0 : record_size(typ[j][3:0]);
         need = {32'd0, cnt} * {32'd0, t_size};
         if ($urandom_range(0, 15) == 0) begin
            size = $urandom;
         end else if (need <= {32'd0, room}) begin
            slack = room - need[31:0];
            if (slack > 4095) slack = 4095;
            size = need[31:0] + $urandom_range(0, slack);
         end else begin
            size = room;
         end
         words.push_back(typ[j]);
         words.push_back(off);
         words.push_back(cnt);
         words.push_back(size);
      end
      if ($urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, words.size() - 1);
         case ($urandom_range(0, 2))
            0: words[k] = $urandom;
            1: words[k] = words[k] ^ (32'd1 << $urandom_range(0, 31));
            default: while (words.size() > k + 1) words.delete(words.size() - 1);
         endcase
      end
      n_words = words.size();
      for (j = 0; j < n_words; j++) send(words[j], j == 0);
      if ($urandom_range(0, 4) == 0) begin
         k = $urandom_range(1, 3);
         for (j = 0; j < k; j++) send($urandom, 1'b0);
      end
   endtask

   initial begin : stimulus
      logic [63:0] magic;
      logic [31:0] version;
      int phase, produced, got;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed checks on a mid-size buffer
      set_config(32'h0010_0000, {$urandom, $urandom}, $urandom);
      send($urandom, 1'b0);
      send(32'hFFFF_FFFF, 1'b0);
      send_header(8);
      send_required();
      send_record(7, 0, 77, 0);
      send_record(1, 0, 65535, 32'd524280);
      send_record(9, cfg_len, 12, 0);
      send_record(2, 500, 0, 0);
      send_header(9);
      send_record(0, 1000, 0, 4);
      send_record(1, 2000, 3, 24);
      send_record(2, 3000, 1, 20);
      send_record(3, 4000, 1, 22);
      send_record(4, 5000, 2, 28);
      send_record(5, 6000, 4, 48);
      send_record(6, 7000, 1, 20);
      send_record(7, 8000, 9, 1);
      send_record(8, 9000, 2, 48);
      send(cfg_magic[31:0], 1'b1);
      send(~cfg_magic[63:32], 1'b0);
      send(~cfg_magic[31:0], 1'b1);
      send(cfg_magic[63:32], 1'b0);
      send_header_part(2, 0);
      send(~cfg_version, 1'b0);
      send_header_part(3, 0);
      send(cfg_len + 1, 1'b0);
      send_header(0);
      send_header(33);
      send_header(1);
      send_record(2, cfg_len + 1, 0, 0);
      send_header(1);
      send_record(2, 16, 0, cfg_len - 15);
      send_header(1);
      send_record(3, 0, 10, 219);
      send_header(3);
      send_record(0, 0, 0, 0);
      send_record(2, 0, 0, 0);
      send_record(3, 0, 0, 0);
      send_header(5);
      send_required();
      send_record(1, 0, 65536, 32'd524288);
      send($urandom, 1'b0);
      send_header_part(3, 0);
      send_header(4);
      send_required();
      settle();

      // short buffers
      set_config(32'd0, 64'd0, 32'd0);
      send(32'hFFFF_FFFF, 1'b1);
      send(32'd0, 1'b0);
      send(32'd0, 1'b1);
      settle();
      set_config(32'd19, {$urandom, $urandom}, $urandom);
      send_header(4);
      settle();

      // section table barely fitting or not
      set_config(32'd20, {$urandom, $urandom}, $urandom);
      send_header(1);
      settle();
      set_config(32'd52, {$urandom, $urandom}, $urandom);
      send_header(3);
      send_header(2);
      send_record(0, 52, 0, 0);
      send_record(2, 0, 2, 40);
      settle();

      // largest buffer, all-ones magic and version
      set_config(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_header(6);
      send_record(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_record(2, 0, 0, 32'hFFFF_FFFF);
      send_record(3, 64, 1, 22);
      send_record(4, 128, 2, 28);
      send_record(8, 0, 65535, 32'd1572840);
      send_record(32'hFFFF_FFFF, 8, 9, 10);
      send_header(1);
      send_record(8, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      settle();

      for (phase = 0; phase < 4; phase++) begin
         case ($urandom_range(0, 3))
            0: magic = '0;
            1: magic = '1;
            default: magic = {$urandom, $urandom};
         endcase
         case ($urandom_range(0, 3))
            0: version = '0;
            1: version = '1;
            default: version = $urandom;
         endcase
         set_config($urandom_range(32'h0001_0000, 32'h0FFF_FFFF), magic, version);
         calm_run = (phase == 3);
         produced = 0;
         while (produced < RANDOM_WORDS / 4 + 1) begin
            send_random_container(got);
            produced += got;
         end
         settle();
      end

      if (error_count == 0) begin
         $display("pack_header_validator_top test passed");
      end else begin
         $display("pack_header_validator_top test failed");
      end
      $finish;
   end

endmodule
